@@ hdl/fspc_pkg.sv @@
package fspc_pkg;

  // Field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned XW     = 9;
  localparam int unsigned YW     = 8;
  localparam int unsigned IdxW   = 18;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Screen geometry
  localparam logic [AddrW-1:0] ROW_LAST      = 32'd239;
  localparam logic [XW-1:0]    TOP_WIDTH     = 9'd400;
  localparam logic [XW-1:0]    BOTTOM_WIDTH  = 9'd320;
  localparam logic [IdxW-1:0]  ROW_PITCH     = 18'd400;
  localparam logic [IdxW-1:0]  BOTTOM_OFFSET = 18'd96040;

  // Colour constants
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] FIVE_MAX     = 8'd31;
  localparam logic [7:0] SIX_MAX      = 8'd63;

  // Source pixel formats; codes above RGB5A1 all mean RGBA4
  localparam logic [2:0] FMT_RGBA8  = 3'd0;
  localparam logic [2:0] FMT_RGB8   = 3'd1;
  localparam logic [2:0] FMT_RGB565 = 3'd2;
  localparam logic [2:0] FMT_RGB5A1 = 3'd3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_BASE    = 3'd0,
    REG_PIXEL_STEP     = 3'd1,
    REG_PIXEL_FORMAT   = 3'd2,
    REG_FILL_WORD      = 3'd3,
    REG_PANEL_LIT      = 3'd4,
    REG_SCREEN_ENABLED = 3'd5,
    REG_BOTTOM_SCREEN  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] active_base;
    logic [31:0] pixel_step;
    logic [2:0]  pixel_format;
    logic [24:0] fill_word;
    logic        panel_lit;
    logic        screen_enabled;
    logic        bottom_screen;
  } cfg_t;

  typedef struct packed {
    logic [XW-1:0] pixel_x;
    logic [YW-1:0] pixel_y;
    logic [31:0]   raw_pixel;
  } in_word_t;

  typedef struct packed {
    logic [AddrW-1:0] fetch_address;
    logic             needs_fetch;
    logic [IdxW-1:0]  buffer_index;
    logic [31:0]      color;
    logic             write_enable;
  } out_word_t;

  // c*255/31 truncated: reciprocal estimate (low by at most one), then one correction
  function automatic logic [7:0] expand5(input logic [4:0] c);
    logic [12:0] p;
    logic [20:0] m;
    logic [7:0]  q;
    logic [12:0] rem;
    p   = {c, 8'b0} - {8'b0, c};
    m   = {p, 8'b0} + {5'b0, p, 3'b0};
    q   = m[20:13];
    rem = p - ({q, 5'b0} - {5'b0, q});
    if (rem >= 13'(FIVE_MAX)) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

  // c*255/63 truncated, same scheme
  function automatic logic [7:0] expand6(input logic [5:0] c);
    logic [13:0] p;
    logic [21:0] m;
    logic [7:0]  q;
    logic [13:0] rem;
    p   = {c, 8'b0} - {8'b0, c};
    m   = {p, 8'b0} + {6'b0, p, 2'b0};
    q   = m[21:14];
    rem = p - ({q, 6'b0} - {6'b0, q});
    if (rem >= 14'(SIX_MAX)) begin
      q = q + 8'd1;
    end
    return q;
  endfunction

endpackage

@@ hdl/fspc_regs.sv @@
module fspc_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fspc_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [fspc_pkg::CfgDataW-1:0]  cfg_data,
  output fspc_pkg::cfg_t                 cfg
);

  fspc_pkg::cfg_t cfg_r;
  fspc_pkg::cfg_t cfg_nxt;

  // registers always take a word
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (fspc_pkg::cfg_idx_t'(cfg_index))
        fspc_pkg::REG_ACTIVE_BASE:    cfg_nxt.active_base    = cfg_data;
        fspc_pkg::REG_PIXEL_STEP:     cfg_nxt.pixel_step     = cfg_data;
        fspc_pkg::REG_PIXEL_FORMAT:   cfg_nxt.pixel_format   = cfg_data[2:0];
        fspc_pkg::REG_FILL_WORD:      cfg_nxt.fill_word      = cfg_data[24:0];
        fspc_pkg::REG_PANEL_LIT:      cfg_nxt.panel_lit      = cfg_data[0];
        fspc_pkg::REG_SCREEN_ENABLED: cfg_nxt.screen_enabled = cfg_data[0];
        fspc_pkg::REG_BOTTOM_SCREEN:  cfg_nxt.bottom_screen  = cfg_data[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/fspc_addr.sv @@
module fspc_addr (
  input  logic                          clk,
  input  fspc_pkg::cfg_t                cfg,
  input  logic [fspc_pkg::XW-1:0]       pixel_x,
  input  logic [fspc_pkg::YW-1:0]       pixel_y,
  input  logic                          write_en,
  output logic [fspc_pkg::AddrW-1:0]    fetch_address,
  output logic [fspc_pkg::IdxW-1:0]     buffer_index,
  output logic                          write_enable
);

  logic [fspc_pkg::AddrW-1:0] row_dist;
  logic [fspc_pkg::AddrW-1:0] row_off_nxt;
  logic [fspc_pkg::AddrW-1:0] col_off_nxt;
  logic [fspc_pkg::IdxW-1:0]  index_nxt;

  logic [fspc_pkg::AddrW-1:0] row_off_r;
  logic [fspc_pkg::AddrW-1:0] col_off_r;
  logic [fspc_pkg::IdxW-1:0]  index_r;
  logic                       we_r;
  logic [fspc_pkg::AddrW-1:0] addr_out_r;
  logic [fspc_pkg::IdxW-1:0]  index_out_r;
  logic                       we_out_r;

  // rows counted from the bottom, wraps for rows past the last
  assign row_dist = fspc_pkg::ROW_LAST - 32'(pixel_y);

  // row offset scaled by bytes per pixel
  always_comb begin
    case (cfg.pixel_format)
      fspc_pkg::FMT_RGBA8: row_off_nxt = {row_dist[29:0], 2'b0};
      fspc_pkg::FMT_RGB8:  row_off_nxt = {row_dist[30:0], 1'b0} + row_dist;
      default:             row_off_nxt = {row_dist[30:0], 1'b0};
    endcase
  end

  // column offset: 9 x 32 product, low word kept
  assign col_off_nxt = 32'(pixel_x) * cfg.pixel_step;

  // output buffer index
  assign index_nxt = 18'(pixel_y) * fspc_pkg::ROW_PITCH + 18'(pixel_x)
                   + (cfg.bottom_screen ? fspc_pkg::BOTTOM_OFFSET : '0);

  // stage 2: partial terms
  always_ff @(posedge clk) begin
    row_off_r <= row_off_nxt;
    col_off_r <= col_off_nxt;
    index_r   <= index_nxt;
    we_r      <= write_en;
  end

  // stage 3: final sum into the output register
  always_ff @(posedge clk) begin
    addr_out_r  <= cfg.active_base + col_off_r + row_off_r;
    index_out_r <= index_r;
    we_out_r    <= we_r;
  end

  assign fetch_address = addr_out_r;
  assign buffer_index  = index_out_r;
  assign write_enable  = we_out_r;

endmodule

@@ hdl/fspc_pix.sv @@
module fspc_pix (
  input  logic           clk,
  input  fspc_pkg::cfg_t cfg,
  input  logic [31:0]    raw_pixel,
  input  logic           write_en,
  output logic [31:0]    color,
  output logic           needs_fetch
);

  logic [15:0] half;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] color_nxt;
  logic        fetch_nxt;

  logic [31:0] color_r;
  logic        fetch_r;
  logic [31:0] color_out_r;
  logic        fetch_out_r;

  assign half = raw_pixel[15:0];

  // unpack and widen channels to eight bits
  always_comb begin
    case (cfg.pixel_format)
      fspc_pkg::FMT_RGBA8: begin
        red   = raw_pixel[31:24];
        green = raw_pixel[23:16];
        blue  = raw_pixel[15:8];
      end
      fspc_pkg::FMT_RGB8: begin
        red   = raw_pixel[23:16];
        green = raw_pixel[15:8];
        blue  = raw_pixel[7:0];
      end
      fspc_pkg::FMT_RGB565: begin
        red   = fspc_pkg::expand5(half[15:11]);
        green = fspc_pkg::expand6(half[10:5]);
        blue  = fspc_pkg::expand5(half[4:0]);
      end
      fspc_pkg::FMT_RGB5A1: begin
        red   = fspc_pkg::expand5(half[15:11]);
        green = fspc_pkg::expand5(half[10:6]);
        blue  = fspc_pkg::expand5(half[5:1]);
      end
      default: begin
        // nibble times 17 is the nibble repeated
        red   = {half[15:12], half[15:12]};
        green = {half[11:8], half[11:8]};
        blue  = {half[7:4], half[7:4]};
      end
    endcase
  end

  // blanking, dark panel and fill override
  always_comb begin
    color_nxt = '0;
    fetch_nxt = 1'b0;
    if (write_en) begin
      if (!cfg.panel_lit) begin
        color_nxt = {fspc_pkg::ALPHA_OPAQUE, 24'h0};
      end else if (cfg.fill_word[24]) begin
        color_nxt = {fspc_pkg::ALPHA_OPAQUE, cfg.fill_word[23:0]};
      end else begin
        color_nxt = {fspc_pkg::ALPHA_OPAQUE, blue, green, red};
        fetch_nxt = 1'b1;
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    color_r <= color_nxt;
    fetch_r <= fetch_nxt;
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    color_out_r <= color_r;
    fetch_out_r <= fetch_r;
  end

  assign color       = color_out_r;
  assign needs_fetch = fetch_out_r;

endmodule

@@ hdl/framebuffer_scanout_pixel_converter_unit.sv @@
// Scanout pixel converter for one screen.
// Input: drive in_word with start high; the word is taken at any edge where
// busy is low. busy never rises, so a new pixel can be issued every cycle.
// Output: out_word is shown for one cycle with out_valid high, after the
// register stages below, in issue order. There is no back-pressure: the
// receiver must take each word in the cycle it appears.
// Throughput is one pixel per cycle; latency is three register stages
// (input capture, column product and colour expand, address sum).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Registers must only be changed while no pixel is in
// flight. Format change alters bytes per pixel in the address.
// Reset (rst_n low, synchronous) clears all configuration registers and the pipeline
// valid bits; words in flight are dropped.
module framebuffer_scanout_pixel_converter_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  fspc_pkg::in_word_t            in_word,
  output logic                          out_valid,
  output fspc_pkg::out_word_t           out_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fspc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fspc_pkg::CfgDataW-1:0] cfg_data
);

  fspc_pkg::cfg_t     cfg;
  fspc_pkg::in_word_t s1_word_r;
  logic               in_accept;
  logic               s1_valid_r;
  logic               s2_valid_r;
  logic               out_valid_r;
  logic               s1_we;
  logic [fspc_pkg::XW-1:0] width;

  logic [fspc_pkg::AddrW-1:0] pipe_addr;
  logic                       pipe_fetch;
  logic [fspc_pkg::IdxW-1:0]  pipe_index;
  logic [31:0]                pipe_color;
  logic                       pipe_we;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  fspc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // valid bits follow the words down the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // stage 1: capture the input word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_word_r <= in_word;
    end
  end

  // write enable: screen on and column inside the screen
  assign width = cfg.bottom_screen ? fspc_pkg::BOTTOM_WIDTH : fspc_pkg::TOP_WIDTH;
  assign s1_we = cfg.screen_enabled && (s1_word_r.pixel_x < width);

  fspc_addr u_addr (
    .clk           (clk),
    .cfg           (cfg),
    .pixel_x       (s1_word_r.pixel_x),
    .pixel_y       (s1_word_r.pixel_y),
    .write_en      (s1_we),
    .fetch_address (pipe_addr),
    .buffer_index  (pipe_index),
    .write_enable  (pipe_we)
  );

  fspc_pix u_pix (
    .clk         (clk),
    .cfg         (cfg),
    .raw_pixel   (s1_word_r.raw_pixel),
    .write_en    (s1_we),
    .color       (pipe_color),
    .needs_fetch (pipe_fetch)
  );

  // gather the result word
  assign out_word  = {pipe_addr, pipe_fetch, pipe_index, pipe_color, pipe_we};
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // every accepted word comes out on out_valid after the pipeline registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##3 out_valid)
    else $error("accepted word did not appear after three cycles");

  // nothing comes out that was not issued
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_valid_r |=> !out_valid)
    else $error("output strobe without a word in the pipe");

  // blanked pixels carry no colour and need no fetch
  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.write_enable) |->
      (out_word.color == 32'h0 && !out_word.needs_fetch))
    else $error("blanked pixel with colour or fetch");

  // written pixels are always opaque
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.write_enable) |-> (out_word.color[31:24] == 8'hFF))
    else $error("written pixel not opaque");
`endif

endmodule

@@ bench/framebuffer_scanout_pixel_converter_unit_tb.sv @@
`timescale 1ns / 100ps

module framebuffer_scanout_pixel_converter_unit_tb;

  // Watchdog and settle times, in clock cycles
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 6;

  // Codes the package leaves unnamed
  localparam logic [fspc_pkg::CfgIdxW-1:0] REG_SPARE = 3'd7;
  localparam logic [2:0]         FMT_RGBA4     = 3'd4;
  localparam logic [2:0]         FMT_RGBA4_ALT = 3'd7;

  // Screen geometry and colour constants, kept apart from the design's copies
  localparam int unsigned TOP_W    = 400;
  localparam int unsigned BOT_W    = 320;
  localparam int unsigned PITCH    = 400;
  localparam int unsigned BOT_BASE = 96040;
  localparam int unsigned LAST_ROW = 239;
  localparam logic [31:0] OPAQUE_BLACK = 32'hFF00_0000;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  fspc_pkg::in_word_t            in_word;
  logic                          out_valid;
  fspc_pkg::out_word_t           out_word;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [fspc_pkg::CfgIdxW-1:0]  cfg_index;
  logic [fspc_pkg::CfgDataW-1:0] cfg_data;

  fspc_pkg::cfg_t      scan_regs;
  fspc_pkg::out_word_t expected_pixels[$];
  int unsigned mismatch_count = 0;
  int unsigned pixels_sent    = 0;
  int unsigned settings_used  = 0;
  int unsigned stall_cycles   = 0;
  bit          idle_bursts    = 1'b0;

  framebuffer_scanout_pixel_converter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Channel widening: c*255/max, quotient truncated
  function automatic logic [7:0] scale_channel(input int unsigned c, input int unsigned maxv);
    return 8'((c * 255) / maxv);
  endfunction

  // Expected output word for one pixel under the current register shadow
  function automatic fspc_pkg::out_word_t convert_pixel(input fspc_pkg::in_word_t w);
    fspc_pkg::out_word_t r;
    logic [31:0] bpp;
    logic [31:0] idx;
    logic [15:0] h;
    logic [31:0] raw;
    int unsigned width;
    r     = '0;
    raw   = w.raw_pixel;
    h     = raw[15:0];
    width = scan_regs.bottom_screen ? BOT_W : TOP_W;
    case (scan_regs.pixel_format)
      fspc_pkg::FMT_RGBA8: bpp = 32'd4;
      fspc_pkg::FMT_RGB8:  bpp = 32'd3;
      default:             bpp = 32'd2;
    endcase
    r.fetch_address = scan_regs.active_base + 32'(w.pixel_x) * scan_regs.pixel_step
                    + (32'(LAST_ROW) - 32'(w.pixel_y)) * bpp;
    idx = 32'(w.pixel_y) * PITCH + 32'(w.pixel_x) + (scan_regs.bottom_screen ? BOT_BASE : 0);
    r.buffer_index = idx[fspc_pkg::IdxW-1:0];
    r.write_enable = scan_regs.screen_enabled && (32'(w.pixel_x) < width);
    if (r.write_enable) begin
      if (!scan_regs.panel_lit) begin
        r.color = OPAQUE_BLACK;
      end else if (scan_regs.fill_word[24]) begin
        r.color = {8'hFF, scan_regs.fill_word[23:0]};
      end else begin
        r.needs_fetch = 1'b1;
        // colour packs as A, B, G, R
        case (scan_regs.pixel_format)
          fspc_pkg::FMT_RGBA8:  r.color = {8'hFF, raw[15:8], raw[23:16], raw[31:24]};
          fspc_pkg::FMT_RGB8:   r.color = {8'hFF, raw[7:0], raw[15:8], raw[23:16]};
          fspc_pkg::FMT_RGB565: r.color = {8'hFF, scale_channel(h[4:0], 31),
                                           scale_channel(h[10:5], 63),
                                           scale_channel(h[15:11], 31)};
          fspc_pkg::FMT_RGB5A1: r.color = {8'hFF, scale_channel(h[5:1], 31),
                                           scale_channel(h[10:6], 31),
                                           scale_channel(h[15:11], 31)};
          default:              r.color = {8'hFF, scale_channel(h[7:4], 15),
                                           scale_channel(h[11:8], 15),
                                           scale_channel(h[15:12], 15)};
        endcase
      end
    end
    return r;
  endfunction

  // Register shadow update, masked to each register's width
  function automatic void apply_reg(input logic [fspc_pkg::CfgIdxW-1:0] idx,
                                    input logic [31:0] data);
    case (idx)
      fspc_pkg::REG_ACTIVE_BASE:    scan_regs.active_base    = data;
      fspc_pkg::REG_PIXEL_STEP:     scan_regs.pixel_step     = data;
      fspc_pkg::REG_PIXEL_FORMAT:   scan_regs.pixel_format   = data[2:0];
      fspc_pkg::REG_FILL_WORD:      scan_regs.fill_word      = data[24:0];
      fspc_pkg::REG_PANEL_LIT:      scan_regs.panel_lit      = data[0];
      fspc_pkg::REG_SCREEN_ENABLED: scan_regs.screen_enabled = data[0];
      fspc_pkg::REG_BOTTOM_SCREEN:  scan_regs.bottom_screen  = data[0];
      default: ;
    endcase
  endfunction

  function automatic fspc_pkg::in_word_t px(input int unsigned x, input int unsigned y,
                                            input logic [31:0] raw);
    fspc_pkg::in_word_t w;
    w.pixel_x   = x[fspc_pkg::XW-1:0];
    w.pixel_y   = y[fspc_pkg::YW-1:0];
    w.raw_pixel = raw;
    return w;
  endfunction

  // Mostly on-screen pixels; the rest anywhere the fields reach
  function automatic fspc_pkg::in_word_t random_pixel(input bit on_screen);
    int unsigned width;
    width = scan_regs.bottom_screen ? BOT_W : TOP_W;
    if (on_screen) begin
      return px($urandom_range(0, width - 1), $urandom_range(0, LAST_ROW), $urandom());
    end
    return px($urandom_range(0, 511), $urandom_range(0, 255), $urandom());
  endfunction

  // Config write: valid stays high across a batch, dropped by finish_cfg
  task automatic write_reg(input logic [fspc_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    apply_reg(idx, data);
  endtask

  task automatic finish_cfg();
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Stop issuing and wait until every pixel in flight has come back
  task automatic drain_pixels();
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Full register set; narrow registers carry junk in their unused bits
  task automatic set_regs(input logic [31:0] base, input logic [31:0] step,
                          input logic [2:0] fmt, input logic [24:0] fill,
                          input bit lit, input bit en, input bit bottom);
    logic [31:0] noise;
    noise = $urandom();
    drain_pixels();
    write_reg(fspc_pkg::REG_ACTIVE_BASE, base);
    write_reg(fspc_pkg::REG_PIXEL_STEP, step);
    write_reg(fspc_pkg::REG_PIXEL_FORMAT, {noise[31:3], fmt});
    write_reg(fspc_pkg::REG_FILL_WORD, {noise[31:25], fill});
    write_reg(fspc_pkg::REG_PANEL_LIT, {noise[31:1], lit});
    write_reg(fspc_pkg::REG_SCREEN_ENABLED, {noise[31:1], en});
    write_reg(fspc_pkg::REG_BOTTOM_SCREEN, {noise[31:1], bottom});
    finish_cfg();
  endtask

  task automatic program_random_setting();
    logic [31:0] base;
    logic [31:0] step;
    case ($urandom_range(0, 3))
      0:       base = 32'h0;
      1:       base = 32'hFFFF_FFFF;
      default: base = $urandom();
    endcase
    case ($urandom_range(0, 4))
      0:       step = 32'h0;
      1:       step = 32'hFFFF_FFF0;
      2:       step = 32'hFFFF_FFFF;
      3:       step = $urandom() & 32'hFFFF_FFF0;
      default: step = $urandom();
    endcase
    set_regs(base, step, 3'($urandom_range(0, 7)),
             {($urandom_range(0, 6) == 0), 24'($urandom())},
             $urandom_range(0, 6) != 0, $urandom_range(0, 9) != 0,
             $urandom_range(0, 1) != 0);
  endtask

  // Issue one pixel word; start stays high into the next call
  task automatic send_pixel(input fspc_pkg::in_word_t w);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      start   <= 1'b0;
      in_word <= px($urandom_range(0, 511), $urandom_range(0, 255), $urandom());
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    expected_pixels.push_back(convert_pixel(w));
    pixels_sent++;
  endtask

  task automatic check_pixel(input fspc_pkg::out_word_t got);
    fspc_pkg::out_word_t want;
    if (expected_pixels.size() == 0) begin
      $error("unexpected output word %h", got);
      mismatch_count++;
    end else begin
      want = expected_pixels.pop_front();
      if (got.fetch_address !== want.fetch_address) begin
        $error("fetch_address: expected %h, got %h", want.fetch_address, got.fetch_address);
        mismatch_count++;
      end
      if (got.needs_fetch !== want.needs_fetch) begin
        $error("needs_fetch: expected %b, got %b", want.needs_fetch, got.needs_fetch);
        mismatch_count++;
      end
      if (got.buffer_index !== want.buffer_index) begin
        $error("buffer_index: expected %0d, got %0d", want.buffer_index, got.buffer_index);
        mismatch_count++;
      end
      if (got.color !== want.color) begin
        $error("color: expected %h, got %h", want.color, got.color);
        mismatch_count++;
      end
      if (got.write_enable !== want.write_enable) begin
        $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
        mismatch_count++;
      end
    end
  endtask

  // Output monitor: every strobed word is taken in its cycle
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      check_pixel(out_word);
    end
  end

  // Watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Registers at reset: screen disabled, nothing written
  task automatic test_reset_state();
    send_pixel(px(0, 0, 32'hFFFF_FFFF));
    send_pixel(px(511, 255, 32'h0000_0000));
  endtask

  // Each source format, plain lit panel, no fill
  task automatic test_formats();
    logic [2:0] fmts [6];
    fmts = '{fspc_pkg::FMT_RGBA8, fspc_pkg::FMT_RGB8, fspc_pkg::FMT_RGB565,
             fspc_pkg::FMT_RGB5A1, FMT_RGBA4, FMT_RGBA4_ALT};
    foreach (fmts[i]) begin
      set_regs(32'h0010_0000, 32'h10, fmts[i], 25'h0, 1'b1, 1'b1, 1'b0);
      send_pixel(px(0, 0, 32'hFFFF_FFFF));
      send_pixel(px(399, 239, 32'h7B9D_4E21));
    end
  endtask

  task automatic test_special_cases();
    // dark panel, with the address sum wrapping at 32 bits
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, fspc_pkg::FMT_RGBA8, 25'h0, 1'b0, 1'b1, 1'b0);
    send_pixel(px(399, 0, 32'hFFFF_FFFF));
    // forced fill, full colour then black fill
    set_regs(32'h8000_0000, 32'hFFFF_FFF0, fspc_pkg::FMT_RGB8, 25'h1FF_FFFF, 1'b1, 1'b1, 1'b0);
    send_pixel(px(0, 239, 32'h1234_5678));
    set_regs(32'h8000_0000, 32'hFFFF_FFF0, fspc_pkg::FMT_RGB8, 25'h100_0000, 1'b1, 1'b1, 1'b0);
    send_pixel(px(200, 100, 32'h89AB_CDEF));
    // top screen width edge, and rows past the last
    set_regs(32'h100, 32'h20, fspc_pkg::FMT_RGB565, 25'h0, 1'b1, 1'b1, 1'b0);
    send_pixel(px(399, 10, 32'h0000_F81F));
    send_pixel(px(400, 10, 32'hFFFF_FFFF));
    send_pixel(px(511, 255, 32'hFFFF_FFFF));
    send_pixel(px(5, 240, 32'h0000_07E0));
    // bottom screen width edge and buffer offset
    set_regs(32'h100, 32'h20, fspc_pkg::FMT_RGB5A1, 25'h0, 1'b1, 1'b1, 1'b1);
    send_pixel(px(319, 239, 32'h0000_FFFE));
    send_pixel(px(320, 0, 32'hFFFF_FFFF));
    send_pixel(px(0, 255, 32'h0000_8421));
    // screen disabled
    set_regs(32'h100, 32'h20, FMT_RGBA4, 25'h0, 1'b1, 1'b0, 1'b0);
    send_pixel(px(10, 10, 32'hFFFF_FFFF));
    // write to the unused index changes nothing
    drain_pixels();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    finish_cfg();
    send_pixel(px(10, 10, 32'hFFFF_FFFF));
  endtask

  // Random settings, each followed by a run of mostly on-screen pixels
  task automatic test_random_traffic();
    for (int p = 0; p < 15; p++) begin
      program_random_setting();
      idle_bursts = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 100; n++) begin
        send_pixel(random_pixel($urandom_range(0, 4) != 0));
      end
    end
  endtask

  // Full rate, no gaps at all
  task automatic test_back_to_back();
    idle_bursts = 1'b0;
    for (int p = 0; p < 2; p++) begin
      program_random_setting();
      for (int n = 0; n < 80; n++) begin
        send_pixel(random_pixel($urandom_range(0, 4) != 0));
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    scan_regs = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_formats();
    test_special_cases();
    test_random_traffic();
    test_back_to_back();

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d pixels across %0d register settings: all formats, fill, dark panel,",
             pixels_sent, settings_used);
    $display("blanking, both screens, address wrap and random gaps between pixels");
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ framebuffer_scanout_pixel_converter_unit.f @@
hdl/fspc_pkg.sv
hdl/fspc_regs.sv
hdl/fspc_addr.sv
hdl/fspc_pix.sv
hdl/framebuffer_scanout_pixel_converter_unit.sv
bench/framebuffer_scanout_pixel_converter_unit_tb.sv
